[src/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, reply codes and the touch sample packing for the touch
// sampling scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_LINE,
      S_STEP,
      S_SCAN,
      S_EMIT
   } tss_state_type;

   // Command byte held in the upper byte of packet word 0
   localparam logic [7:0] OP_MANUAL = 8'd0;
   localparam logic [7:0] OP_SETUP  = 8'd1;
   localparam logic [7:0] OP_STOP   = 8'd2;
   localparam logic [7:0] OP_COND   = 8'd3;

   // Sampler status codes
   localparam logic [1:0] STATUS_IDLE    = 2'd0;
   localparam logic [1:0] STATUS_RUNNING = 2'd2;

   // Reply payloads (service 6, flag 0)
   localparam logic [25:0] REPLY_MANUAL    = 26'h3008000;
   localparam logic [25:0] REPLY_SETUP     = 26'h3008100;
   localparam logic [25:0] REPLY_BAD_ARG   = 26'h3008102;
   localparam logic [25:0] REPLY_BAD_STATE = 26'h3008103;
   localparam logic [25:0] REPLY_STOP      = 26'h3008200;
   localparam logic [25:0] REPLY_COND      = 26'h3008300;
   localparam logic [25:0] REPLY_SCAN      = 26'h3009000;

   // Touch status word flag masks
   localparam logic [31:0] KEEP_NO_TOUCH = 32'hFE000000;
   localparam logic [31:0] SET_NO_TOUCH  = 32'h06000000;
   localparam logic [31:0] KEEP_TOUCH    = 32'hF9000000;
   localparam logic [31:0] SET_TOUCH     = 32'h01000000;
   localparam logic [11:0] Y_NO_TOUCH    = 12'hFFF;

   // Fold a pen reading into the stored touch status word
   function automatic logic [31:0] take_sample(input logic [31:0] ts,
                                               input logic [11:0] x,
                                               input logic [11:0] y);
      logic [31:0] res;
      if (y == Y_NO_TOUCH) begin
         res = (ts & KEEP_NO_TOUCH) | SET_NO_TOUCH;
      end else begin
         res = (ts & KEEP_TOUCH) | {8'h00, y, x} | SET_TOUCH;
      end
      return res;
   endfunction

endpackage

[src/touch_sampling_scheduler.sv]
// ----------------------------------------------------------------------------
// touch_sampling_scheduler
// Touch service: packet buffer, command decode, auto-sampling line set-up
// and per-scanline sampling around one shared subtract/compare unit.
// ----------------------------------------------------------------------------
// One item is taken at a time; req_tready is high only while the sequencer
// is idle. A request word without its execute bit passes through decode
// and gives no result. Manual sample, conditional sample, stop and every
// refused set-up pass through decode, then emit, where the result is
// loaded. An accepted set-up runs a restoring divide of the frame length
// by the sample count N over the LW bits of LINES_PER_FRAME, then for each
// sample line wraps the line and then advances the step. A scanline event
// compares the sample lines up to and including the first match (all of
// them when none matches). The divide, the wrap and step work and the
// compares all go through the same subtract/compare unit. Results sit in
// an output register, so a result that is not yet taken only delays the
// loading of the next one. Reset clears the sequencer, status, packet
// buffer, sample lines, touch word and output valid.
module touch_sampling_scheduler
   import tss_pkg::*;
#(
   parameter int LINES_PER_FRAME = 263,
   parameter int MAX_SAMPLES     = 4,
   parameter int PACKET_WORDS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [25:0] request_word, [34:26] scanline_number, [46:35] touch_x,
   // [58:47] touch_y, [63:59] zero
   input  logic [63:0] req_tdata,
   // [0] cmd
   input  logic [0:0]  req_tuser,
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [25:0] reply_data, [57:26] touch_word, [63:58] zero
   output logic [63:0] rsp_tdata,
   // [0] touch_word_valid
   output logic [0:0]  rsp_tuser
);

   // Widths that follow from the parameters
   localparam int LW   = $clog2(LINES_PER_FRAME + 1);     // a line number or a step
   localparam int CNTW = $clog2(MAX_SAMPLES + 1);         // sample count / index
   localparam int IW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int PIW  = $clog2(PACKET_WORDS);
   localparam int BW   = $clog2(LW);
   localparam int UW0  = (LW > CNTW) ? LW + 1 : CNTW + 1;
   localparam int UW   = (UW0 > 9) ? UW0 : 9;              // shared unit width
   localparam logic [LW-1:0] LPF = LW'(LINES_PER_FRAME);

   // Input item fields
   logic        in_cmd;
   logic [25:0] in_rq;
   logic [8:0]  in_line;
   logic [11:0] in_x;
   logic [11:0] in_y;
   logic [3:0]  in_slot;

   assign in_cmd  = req_tuser[0];
   assign in_rq   = req_tdata[25:0];
   assign in_line = req_tdata[34:26];
   assign in_x    = req_tdata[46:35];
   assign in_y    = req_tdata[58:47];
   assign in_slot = in_rq[19:16];

   // Registers
   tss_state_type  state_ff, state_in;
   logic [25:0]    rq_ff, rq_in;
   logic [8:0]     line_ff, line_in;
   logic [11:0]    x_ff, x_in;
   logic [11:0]    y_ff, y_in;
   logic [15:0]    pkt_ff [PACKET_WORDS];
   logic [15:0]    pkt_in [PACKET_WORDS];
   logic [1:0]     status_ff, status_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [LW-1:0]  lines_ff [MAX_SAMPLES];
   logic [LW-1:0]  lines_in [MAX_SAMPLES];
   logic [31:0]    touch_ff, touch_in;
   logic [LW-1:0]  offset_ff, offset_in;
   logic [CNTW-1:0] rem_ff, rem_in;
   logic [CNTW-1:0] acc_ff, acc_in;
   logic [LW-1:0]  quo_ff, quo_in;
   logic [BW-1:0]  bit_ff, bit_in;
   logic [LW-1:0]  step_ff, step_in;
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [25:0]    pend_reply_ff, pend_reply_in;
   logic           pend_sample_ff, pend_sample_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [25:0]    rsp_reply_ff, rsp_reply_in;
   logic           rsp_sample_ff, rsp_sample_in;
   logic [31:0]    rsp_word_ff, rsp_word_in;

   // Shared subtract/compare unit
   logic [UW-1:0] alu_a;
   logic [UW-1:0] alu_b;
   logic [UW-1:0] alu_diff;
   logic          alu_borrow;
   logic          alu_ge;
   logic          alu_eq;

   assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge = ~alu_borrow;
   assign alu_eq = (alu_diff == '0);

   // Decode helpers
   logic [7:0]  op;
   logic [7:0]  num;
   logic        num_bad;
   logic        offset_bad;
   logic        idx_last;
   logic        scan_done;
   logic        out_free;
   logic [31:0] sample_word;

   assign op          = pkt_ff[0][15:8];
   assign num         = pkt_ff[0][7:0];
   assign num_bad     = (num == 8'd0) || (num > 8'(MAX_SAMPLES));
   assign offset_bad  = (pkt_ff[1] >= 16'(LINES_PER_FRAME));
   assign idx_last    = ((idx_ff + 1'b1) == count_ff);
   assign scan_done   = (idx_ff >= count_ff);
   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign sample_word = take_sample(touch_ff, x_ff, y_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_word_ff, rsp_reply_ff};
   assign rsp_tuser  = rsp_sample_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = in_cmd ? S_SCAN : S_DECODE;
            end
         end
         S_DECODE: begin
            if (!rq_ff[24]) begin
               state_in = S_IDLE;
            end else begin
               unique case (op)
                  OP_MANUAL, OP_COND, OP_STOP: state_in = S_EMIT;
                  OP_SETUP: begin
                     if (status_ff != STATUS_IDLE || num_bad || offset_bad) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            if (bit_ff == '0) begin
               state_in = S_LINE;
            end
         end
         S_LINE: state_in = S_STEP;
         S_STEP: begin
            state_in = idx_last ? S_EMIT : S_LINE;
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_IDLE;
            end else if (alu_eq) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      rq_in          = rq_ff;
      line_in        = line_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      pkt_in         = pkt_ff;
      status_in      = status_ff;
      count_in       = count_ff;
      lines_in       = lines_ff;
      touch_in       = touch_ff;
      offset_in      = offset_ff;
      rem_in         = rem_ff;
      acc_in         = acc_ff;
      quo_in         = quo_ff;
      bit_in         = bit_ff;
      step_in        = step_ff;
      idx_in         = idx_ff;
      pend_reply_in  = pend_reply_ff;
      pend_sample_in = pend_sample_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_reply_in   = rsp_reply_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_word_in    = rsp_word_ff;
      alu_a          = '0;
      alu_b          = '0;

      // Drop the output item once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rq_in   = in_rq;
               line_in = in_line;
               x_in    = in_x;
               y_in    = in_y;
               idx_in  = '0;
               // Clear first, then store the value in its slot
               if (!in_cmd) begin
                  if (in_rq[25]) begin
                     for (int i = 0; i < PACKET_WORDS; i++) begin
                        pkt_in[i] = '0;
                     end
                  end
                  if ({1'b0, in_slot} < 5'(PACKET_WORDS)) begin
                     pkt_in[in_slot[PIW-1:0]] = in_rq[15:0];
                  end
               end
            end
         end
         S_DECODE: begin
            pend_sample_in = 1'b0;
            unique case (op)
               OP_MANUAL: begin
                  pend_reply_in  = REPLY_MANUAL;
                  pend_sample_in = 1'b1;
               end
               OP_COND: begin
                  pend_reply_in  = REPLY_COND;
                  pend_sample_in = 1'b1;
               end
               OP_STOP: begin
                  if (status_ff != STATUS_RUNNING) begin
                     pend_reply_in = REPLY_BAD_STATE;
                  end else begin
                     pend_reply_in = REPLY_STOP;
                     if (rq_ff[24]) begin
                        count_in  = '0;
                        status_in = STATUS_IDLE;
                     end
                  end
               end
               OP_SETUP: begin
                  priority if (status_ff != STATUS_IDLE) begin
                     pend_reply_in = REPLY_BAD_STATE;
                  end else if (num_bad || offset_bad) begin
                     pend_reply_in = REPLY_BAD_ARG;
                  end else begin
                     pend_reply_in = REPLY_SETUP;
                     if (rq_ff[24]) begin
                        count_in  = num[CNTW-1:0];
                        status_in = STATUS_RUNNING;
                        offset_in = pkt_ff[1][LW-1:0];
                        rem_in    = '0;
                        acc_in    = '0;
                        quo_in    = '0;
                        bit_in    = BW'(LW - 1);
                     end
                  end
               end
               default: pend_reply_in = pend_reply_ff;
            endcase
         end
         S_DIV: begin
            // One quotient bit of frame length / count per cycle
            alu_a  = UW'({rem_ff, LPF[bit_ff]});
            alu_b  = UW'(count_ff);
            rem_in = alu_ge ? alu_diff[CNTW-1:0] : alu_a[CNTW-1:0];
            quo_in = {quo_ff[LW-2:0], alu_ge};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               step_in = '0;
               idx_in  = '0;
            end
         end
         S_LINE: begin
            // Wrap offset + step into the frame
            alu_a = UW'(offset_ff) + UW'(step_ff);
            alu_b = UW'(LPF);
            lines_in[idx_ff[IW-1:0]] = alu_ge ? alu_diff[LW-1:0] : alu_a[LW-1:0];
         end
         S_STEP: begin
            // Advance the step by the quotient, plus one when the running
            // remainder reaches the count
            alu_a   = UW'(acc_ff) + UW'(rem_ff);
            alu_b   = UW'(count_ff);
            acc_in  = alu_ge ? alu_diff[CNTW-1:0] : alu_a[CNTW-1:0];
            step_in = step_ff + quo_ff + LW'(alu_ge);
            idx_in  = idx_ff + 1'b1;
         end
         S_SCAN: begin
            alu_a = UW'(line_ff);
            alu_b = UW'(lines_ff[idx_ff[IW-1:0]]);
            if (!scan_done) begin
               if (alu_eq) begin
                  pend_reply_in  = REPLY_SCAN | 26'(idx_ff);
                  pend_sample_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_EMIT: begin
            // Load the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_reply_in  = pend_reply_ff;
               rsp_sample_in = pend_sample_ff;
               rsp_word_in   = pend_sample_ff ? sample_word : '0;
               if (pend_sample_ff) begin
                  touch_in = sample_word;
               end
            end
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STATUS_IDLE;
         count_ff     <= '0;
         touch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PACKET_WORDS; i++) begin
            pkt_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_SAMPLES; i++) begin
            lines_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         touch_ff     <= touch_in;
         rsp_valid_ff <= rsp_valid_in;
         pkt_ff       <= pkt_in;
         lines_ff     <= lines_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff          <= rq_in;
      line_ff        <= line_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      offset_ff      <= offset_in;
      rem_ff         <= rem_in;
      acc_ff         <= acc_in;
      quo_ff         <= quo_in;
      bit_ff         <= bit_in;
      step_ff        <= step_in;
      idx_ff         <= idx_in;
      pend_reply_ff  <= pend_reply_in;
      pend_sample_ff <= pend_sample_in;
      rsp_reply_ff   <= rsp_reply_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_word_ff    <= rsp_word_in;
   end

endmodule

[src/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// Port-level assertions for the touch sampling scheduler.
// ----------------------------------------------------------------------------
module tss_checker
   import tss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // One item at a time: no input taken in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // Every reply is a service 6 payload, padding zero
   a_reply_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:16] == REPLY_MANUAL[25:16] && rsp_tdata[63:58] == 6'd0)
      else $error("malformed reply payload");

   // No sample flag, no touch word
   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[57:26] == 32'd0)
      else $error("touch word present without sample flag");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind touch_sampling_scheduler tss_checker u_tss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[bench/tb_touch_sampling_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_touch_sampling_scheduler
// Self-checking bench for the touch sampling scheduler. A directed table
// covers the reply codes, the set-up argument checks, the state checks and the
// extreme request words. A long random run follows, built mostly from set-up,
// scanline, sample and stop sequences with some noise words mixed in. Every
// result item is checked field by field against its typed row or a local
// model of the touch service. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_touch_sampling_scheduler;
   import tss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LINES  = 263;
   localparam int SAMPLE_SLOTS = 4;
   localparam int BUF_WORDS    = 16;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [7:0] OP_UNUSED = 8'hFF;

   // One result item as the block returns it
   typedef struct packed {
      logic [25:0] reply;
      logic        fresh;
      logic [31:0] word;
   } touch_rsp_type;

   // One row of the directed plan; want is only used when fixed is set
   typedef struct {
      bit            cmd;
      logic [25:0]   req;
      logic [8:0]    line;
      logic [11:0]   x;
      logic [11:0]   y;
      bit            fixed;
      touch_rsp_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // Model state of the touch service
   logic [15:0] buf_words [BUF_WORDS];
   logic [1:0]  sampler_mode;
   int          line_count;
   int          line_table [SAMPLE_SLOTS];
   logic [31:0] pen_word;

   touch_rsp_type pending_rsps [$];
   plan_row_type  plan [$];
   int            err_count = 0;
   int            cycle_count = 0;
   int            rsp_hold = 0;
   bit            quiet = 1'b0;
   touch_rsp_type mon_want;
   touch_rsp_type mon_got;

   touch_sampling_scheduler #(
      .LINES_PER_FRAME(FRAME_LINES),
      .MAX_SAMPLES(SAMPLE_SLOTS),
      .PACKET_WORDS(BUF_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Build a request word: clear, execute, slot and 16-bit value
   function automatic logic [25:0] mk_req(input bit clr, input bit exec,
                                          input logic [3:0] slot,
                                          input logic [15:0] value);
      return {clr, exec, 4'h0, slot, value};
   endfunction

   function automatic plan_row_type row(input bit cmd, input logic [25:0] req,
                                        input logic [8:0] line,
                                        input logic [11:0] x, input logic [11:0] y,
                                        input bit fixed, input logic [25:0] reply,
                                        input logic fresh, input logic [31:0] word);
      plan_row_type r;
      r.cmd = cmd;
      r.req = req;
      r.line = line;
      r.x = x;
      r.y = y;
      r.fixed = fixed;
      r.want = '{reply: reply, fresh: fresh, word: word};
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none in a quiet stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Fold a pen reading into the stored touch word and return it
   function automatic logic [31:0] fold_pen(input logic [11:0] x,
                                            input logic [11:0] y);
      if (y == 12'hFFF) begin
         pen_word = {pen_word[31:25], 25'd0} | SET_NO_TOUCH;
      end else begin
         pen_word[23:0]  = {y, x};
         pen_word[26:25] = 2'b00;
         pen_word[24]    = 1'b1;
      end
      return pen_word;
   endfunction

   function automatic void reset_model();
      foreach (buf_words[i]) buf_words[i] = '0;
      foreach (line_table[i]) line_table[i] = 0;
      sampler_mode = STATUS_IDLE;
      line_count = 0;
      pen_word = '0;
   endfunction

   // Advance the model by one accepted item; hit says a result is due
   function automatic bit predict_touch(input bit cmd, input logic [25:0] req,
                                        input logic [8:0] line,
                                        input logic [11:0] x, input logic [11:0] y,
                                        output touch_rsp_type r);
      logic [7:0] op;
      int         num;
      int         offset;
      r = '0;
      if (cmd) begin
         for (int i = 0; i < line_count; i++) begin
            if (int'(line) == line_table[i]) begin
               r.reply = REPLY_SCAN | 26'(i);
               r.fresh = 1'b1;
               r.word  = fold_pen(x, y);
               return 1'b1;
            end
         end
         return 1'b0;
      end
      if (req[25]) foreach (buf_words[i]) buf_words[i] = '0;
      if (int'(req[19:16]) < BUF_WORDS) buf_words[req[19:16]] = req[15:0];
      if (!req[24]) return 1'b0;
      op = buf_words[0][15:8];
      case (op)
         OP_MANUAL, OP_COND: begin
            r.reply = (op == OP_MANUAL) ? REPLY_MANUAL : REPLY_COND;
            r.fresh = 1'b1;
            r.word  = fold_pen(x, y);
         end
         OP_SETUP: begin
            num = int'(buf_words[0][7:0]);
            offset = int'(buf_words[1]);
            if (sampler_mode != STATUS_IDLE) begin
               r.reply = REPLY_BAD_STATE;
            end else if (num == 0 || num > SAMPLE_SLOTS || offset >= FRAME_LINES) begin
               r.reply = REPLY_BAD_ARG;
            end else begin
               line_count = num;
               for (int i = 0; i < num; i++)
                  line_table[i] = (offset + (i * FRAME_LINES) / num) % FRAME_LINES;
               sampler_mode = STATUS_RUNNING;
               r.reply = REPLY_SETUP;
            end
         end
         OP_STOP: begin
            if (sampler_mode != STATUS_RUNNING) begin
               r.reply = REPLY_BAD_STATE;
            end else begin
               line_count = 0;
               sampler_mode = STATUS_IDLE;
               r.reply = REPLY_STOP;
            end
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Offer one item, hold it until taken, then queue what it should cause
   task automatic drive_item(input bit cmd, input logic [25:0] req,
                             input logic [8:0] line,
                             input logic [11:0] x, input logic [11:0] y,
                             input bit fixed, input touch_rsp_type want);
      touch_rsp_type r;
      bit            hit;
      int            gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, y, x, line, req};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = predict_touch(cmd, req, line, x, y, r);
      // A typed row carries its own expectation; the model only tracks state
      if (fixed) pending_rsps.push_back(want);
      else if (hit) pending_rsps.push_back(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random pen reading with a fair share of no-touch
   task automatic drive_random(input bit cmd, input logic [25:0] req,
                               input logic [8:0] line);
      logic [11:0] y;
      y = ($urandom_range(0, 4) == 0) ? 12'hFFF : 12'($urandom_range(0, 4095));
      drive_item(cmd, req, line, 12'($urandom_range(0, 4095)), y, 1'b0, '0);
   endtask

   function automatic logic [8:0] pick_line();
      if (sampler_mode == STATUS_RUNNING && $urandom_range(0, 3) != 0)
         return 9'(line_table[$urandom_range(0, line_count - 1)]);
      if ($urandom_range(0, 5) == 0) return 9'($urandom_range(FRAME_LINES, 511));
      return 9'($urandom_range(0, FRAME_LINES - 1));
   endfunction

   // Result checker: compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mon_got = '{reply: rsp_tdata[25:0], fresh: rsp_tuser[0], word: rsp_tdata[57:26]};
         if (pending_rsps.size() == 0) begin
            $error("result with none expected: reply_data %h", mon_got.reply);
            err_count++;
         end else begin
            mon_want = pending_rsps.pop_front();
            if (mon_got.reply !== mon_want.reply) begin
               $error("reply_data: expected %h, got %h", mon_want.reply, mon_got.reply);
               err_count++;
            end
            if (mon_got.fresh !== mon_want.fresh) begin
               $error("touch_word_valid: expected %b, got %b",
                      mon_want.fresh, mon_got.fresh);
               err_count++;
            end
            if (mon_got.word !== mon_want.word) begin
               $error("touch_word: expected %h, got %h", mon_want.word, mon_got.word);
               err_count++;
            end
         end
      end
   end

   // Receiver stalls: drop ready for a random stretch now and then
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int          sent;
      int          r;
      logic [15:0] cnt;
      logic [15:0] off;

      reset_model();
      // Directed plan: typed rows are read straight off the reply codes
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_MANUAL, 8'h00}), 0, 12'hABC, 12'h123,
                         1, REPLY_MANUAL, 1, 32'h01123ABC));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_MANUAL, 8'h00}), 0, 12'h000, 12'hFFF,
                         1, REPLY_MANUAL, 1, 32'h06000000));
      // All ones: clear, write slot 15, execute the now empty word 0
      plan.push_back(row(0, 26'h3FFFFFF, 9'h1FF, 12'hFFF, 12'hFFE,
                         1, REPLY_MANUAL, 1, 32'h01FFEFFF));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_STOP, 8'h00}), 0, 0, 0,
                         1, REPLY_BAD_STATE, 0, 0));
      plan.push_back(row(0, mk_req(1, 1, 0, {OP_SETUP, 8'h00}), 0, 0, 0,
                         1, REPLY_BAD_ARG, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h05}), 0, 0, 0,
                         1, REPLY_BAD_ARG, 0, 0));
      plan.push_back(row(0, mk_req(0, 0, 1, 16'd263), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h04}), 0, 0, 0,
                         1, REPLY_BAD_ARG, 0, 0));
      plan.push_back(row(0, mk_req(0, 0, 1, 16'hFFFF), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h04}), 0, 0, 0,
                         1, REPLY_BAD_ARG, 0, 0));
      plan.push_back(row(0, mk_req(0, 0, 1, 16'd262), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h04}), 0, 0, 0,
                         1, REPLY_SETUP, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h04}), 0, 0, 0,
                         1, REPLY_BAD_STATE, 0, 0));
      // Lines now sit at 262, 64, 130 and 196
      plan.push_back(row(1, 26'h2AAAAAA, 9'd262, 12'h555, 12'hAAA, 0, '0, 0, 0));
      plan.push_back(row(1, 26'h1555555, 9'd196, 12'hFFF, 12'h000, 0, '0, 0, 0));
      plan.push_back(row(1, 0, 9'd511, 12'h123, 12'h456, 0, '0, 0, 0));
      plan.push_back(row(1, 0, 9'd263, 12'h123, 12'h456, 0, '0, 0, 0));
      plan.push_back(row(1, 0, 9'd0, 12'h123, 12'h456, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_COND, 8'h00}), 0, 12'h000, 12'h000,
                         0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_UNUSED, 8'hFF}), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 0, 15, 16'h0000), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_STOP, 8'h00}), 0, 0, 0,
                         1, REPLY_STOP, 0, 0));
      plan.push_back(row(1, 0, 9'd262, 12'h321, 12'h654, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(1, 0, 1, 16'd0), 0, 0, 0, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_SETUP, 8'h01}), 0, 0, 0,
                         1, REPLY_SETUP, 0, 0));
      plan.push_back(row(1, 0, 9'd0, 12'h800, 12'hFFF, 0, '0, 0, 0));
      plan.push_back(row(0, mk_req(0, 1, 0, {OP_STOP, 8'h00}), 0, 0, 0,
                         1, REPLY_STOP, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         drive_item(plan[i].cmd, plan[i].req, plan[i].line, plan[i].x, plan[i].y,
                    plan[i].fixed, plan[i].want);

      // Random part: mostly well-formed set-up, scan, sample and stop runs
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 35) begin
            drive_random(1'b1, 26'($urandom), pick_line());
            sent++;
         end else if (r < 50) begin
            // Stop first most of the time so that the set-up gets through
            if (sampler_mode == STATUS_RUNNING && $urandom_range(0, 3) != 0) begin
               drive_random(1'b0, mk_req(0, 1, 0, {OP_STOP, 8'($urandom)}), pick_line());
               sent++;
            end
            off = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(FRAME_LINES, 65535))
                                              : 16'($urandom_range(0, FRAME_LINES - 1));
            cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                                              : 16'($urandom_range(1, SAMPLE_SLOTS));
            drive_random(1'b0, mk_req(1, 0, 1, off), pick_line());
            drive_random(1'b0, mk_req(0, 1, 0, {OP_SETUP, cnt[7:0]}), pick_line());
            sent += 2;
         end else if (r < 58) begin
            drive_random(1'b0, mk_req(1'($urandom_range(0, 1)), 1, 0,
                                      {OP_STOP, 8'($urandom)}), pick_line());
            sent++;
         end else if (r < 78) begin
            drive_random(1'b0, mk_req(1'($urandom_range(0, 1)), 1, 0,
                                      {($urandom_range(0, 1) ? OP_COND : OP_MANUAL),
                                       8'($urandom)}), pick_line());
            sent++;
         end else if (r < 88) begin
            drive_random(1'b0, mk_req($urandom_range(0, 7) == 0, 0,
                                      4'($urandom), 16'($urandom)), pick_line());
            sent++;
         end else begin
            // Noise: any word at all, unused bits and odd commands included
            drive_random(1'b0, 26'($urandom), 9'($urandom));
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      // Hold on a little so that a stray late result is still caught
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
